// File: rtl/plst_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps

package plst_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = 9;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 5;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REM_LAST  = 3'd2,
        OP_REM_AT    = 3'd3,
        OP_DUMP      = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic dump_step;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic cnt_gt1;
        logic dump_end;
    } stat_t;

endpackage

// File: rtl/plst_ctrl.sv
// Controller state machine: input acceptance and dump sequencing.
`timescale 1ns / 1ps

module plst_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plst_pkg::OP_W-1:0]       op,
    input  plst_pkg::stat_t                 stat,
    output plst_pkg::cmd_t                  cmd
);

    plst_pkg::state_t state_reg;
    plst_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.dump_step = 1'b0;
        case (state_reg)
            plst_pkg::S_IDLE:
            begin
                s_tready   = stat.out_free;
                cmd.accept = s_tvalid && stat.out_free;
                if (cmd.accept && (plst_pkg::op_t'(op) == plst_pkg::OP_DUMP) && stat.cnt_gt1)
                begin
                    state_next = plst_pkg::S_DUMP;
                end
            end
            plst_pkg::S_DUMP:
            begin
                cmd.dump_step = stat.out_free;
                if (stat.out_free && stat.dump_end)
                begin
                    state_next = plst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plst_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // No new beat is taken while a dump is still streaming
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plst_pkg::S_DUMP) |-> !cmd.accept)
        else $error("input accepted during dump");

    // A dump only finishes on a step
    a_dump_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == plst_pkg::S_DUMP) && (state_next == plst_pkg::S_IDLE)) |-> cmd.dump_step)
        else $error("dump left without a final step");
`endif

endmodule

// File: rtl/plst_dp.sv
// Datapath: element register file, count, dump index and output register.
`timescale 1ns / 1ps

module plst_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [plst_pkg::OP_W-1:0]       op,
    input  logic [plst_pkg::DATA_W-1:0]     value,
    input  logic [plst_pkg::POS_W-1:0]      position,
    input  plst_pkg::cmd_t                  cmd,
    output plst_pkg::stat_t                 stat,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [plst_pkg::ST_W-1:0]       status,
    output logic [plst_pkg::DATA_W-1:0]     element,
    output logic                            last,
    output logic [plst_pkg::LEN_W-1:0]      length
);

    logic [plst_pkg::DATA_W-1:0]  elem_reg  [plst_pkg::CAPACITY];
    logic [plst_pkg::DATA_W-1:0]  elem_next [plst_pkg::CAPACITY];
    logic [plst_pkg::CNT_W-1:0]   count_reg;
    logic [plst_pkg::CNT_W-1:0]   count_next;
    logic [plst_pkg::IDX_W-1:0]   dump_idx_reg;
    logic [plst_pkg::IDX_W-1:0]   dump_idx_next;
    logic                         valid_reg;
    logic [plst_pkg::ST_W-1:0]    status_reg;
    logic [plst_pkg::DATA_W-1:0]  element_reg;
    logic                         last_reg;
    logic [plst_pkg::LEN_W-1:0]   length_reg;

    logic                         load;
    plst_pkg::status_t            st;
    logic [plst_pkg::DATA_W-1:0]  el;
    logic                         lst;
    logic [plst_pkg::CMP_W-1:0]   pos_w;
    logic [plst_pkg::CMP_W-1:0]   cnt_w;
    logic [plst_pkg::IDX_W-1:0]   pidx;
    logic                         full;

    assign pos_w = plst_pkg::CMP_W'(position);
    assign cnt_w = plst_pkg::CMP_W'(count_reg);
    assign pidx  = plst_pkg::IDX_W'(position - plst_pkg::POS_W'(1));
    assign full  = (count_reg >= plst_pkg::CNT_W'(plst_pkg::CAPACITY));

    // Status towards the controller
    assign stat.out_free = !valid_reg || m_tready;
    assign stat.cnt_gt1  = (count_reg > plst_pkg::CNT_W'(1));
    assign stat.dump_end = ((plst_pkg::CNT_W'(dump_idx_reg) + plst_pkg::CNT_W'(1)) == count_reg);

    // Execute the operation and form the result beat
    always_comb
    begin
        elem_next     = elem_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        load          = 1'b0;
        st            = plst_pkg::ST_OK;
        el            = '0;
        lst           = 1'b1;
        if (cmd.accept)
        begin
            dump_idx_next = plst_pkg::IDX_W'(1);
            case (plst_pkg::op_t'(op))
                plst_pkg::OP_APPEND:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        st = plst_pkg::ST_FULL;
                    end
                    else
                    begin
                        elem_next[plst_pkg::IDX_W'(count_reg)] = value;
                        count_next = count_reg + plst_pkg::CNT_W'(1);
                    end
                end
                plst_pkg::OP_INSERT:
                begin
                    load = 1'b1;
                    if ((pos_w == '0) || (pos_w > (cnt_w + plst_pkg::CMP_W'(1))))
                    begin
                        st = plst_pkg::ST_BADPOS;
                    end
                    else if (full)
                    begin
                        st = plst_pkg::ST_FULL;
                    end
                    else
                    begin
                        // Shift entries at and above the slot up by one
                        for (int i = 1; i < plst_pkg::CAPACITY; i++)
                        begin
                            if (i > int'(pidx))
                            begin
                                elem_next[i] = elem_reg[i-1];
                            end
                        end
                        elem_next[pidx] = value;
                        count_next = count_reg + plst_pkg::CNT_W'(1);
                    end
                end
                plst_pkg::OP_REM_LAST:
                begin
                    load = 1'b1;
                    if (count_reg == '0)
                    begin
                        st = plst_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - plst_pkg::CNT_W'(1);
                    end
                end
                plst_pkg::OP_REM_AT:
                begin
                    load = 1'b1;
                    if (count_reg == '0)
                    begin
                        st = plst_pkg::ST_EMPTY;
                    end
                    else if ((pos_w == '0) || (pos_w > cnt_w))
                    begin
                        st = plst_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        // Close the gap by shifting later entries down
                        for (int i = 0; i < plst_pkg::CAPACITY - 1; i++)
                        begin
                            if (i >= int'(pidx))
                            begin
                                elem_next[i] = elem_reg[i+1];
                            end
                        end
                        count_next = count_reg - plst_pkg::CNT_W'(1);
                    end
                end
                plst_pkg::OP_DUMP:
                begin
                    load = 1'b1;
                    if (count_reg == '0)
                    begin
                        st = plst_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        el  = elem_reg[0];
                        lst = (count_reg == plst_pkg::CNT_W'(1));
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
        else if (cmd.dump_step)
        begin
            load          = 1'b1;
            el            = elem_reg[dump_idx_reg];
            lst           = stat.dump_end;
            dump_idx_next = dump_idx_reg + plst_pkg::IDX_W'(1);
        end
    end

    // Hold the elements
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    // Advance count, dump index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= st;
            element_reg <= el;
            last_reg    <= lst;
            length_reg  <= plst_pkg::LEN_W'(count_next);
        end
    end

    assign m_tvalid = valid_reg;
    assign status   = status_reg;
    assign element  = element_reg;
    assign last     = last_reg;
    assign length   = length_reg;

`ifndef SYNTHESIS
    // Count stays within capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plst_pkg::CNT_W'(plst_pkg::CAPACITY))
        else $error("count above capacity");

    // A waiting beat is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && valid_reg) |-> m_tready)
        else $error("result beat overwritten");

    // Count only moves on an accepted beat
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |-> cmd.accept)
        else $error("count changed without an accepted beat");

    // Dump reads stay inside the list
    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_step |-> (plst_pkg::CNT_W'(dump_idx_reg) < count_reg))
        else $error("dump index past end of list");
`endif

endmodule

// File: rtl/positional_list_store.sv
// Top level of the positional list store: stream ports, controller and datapath.
`timescale 1ns / 1ps
// A result beat appears in the cycle after its input beat is accepted.
// Change operations take one input beat per cycle; a dump of N elements
// streams N beats, one per cycle, with the input held off until the last.
// The single output register sets the rate; downstream stalls back-pressure.
// Reset (rst_n low, asynchronous) empties the list and clears the output.

module positional_list_store
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value [31:0], position [39:32]
    input  logic [plst_pkg::S_DATA_W-1:0]       s_tdata,
    // operation [2:0]
    input  logic [plst_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // element [31:0], length [36:32], zeros [39:37]
    output logic [plst_pkg::M_DATA_W-1:0]       m_tdata,
    // status [1:0]
    output logic [plst_pkg::ST_W-1:0]           m_tuser,
    output logic                                m_tlast
);

    plst_pkg::cmd_t                 cmd;
    plst_pkg::stat_t                stat;
    logic [plst_pkg::DATA_W-1:0]    element;
    logic [plst_pkg::LEN_W-1:0]     length;

    plst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    plst_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (s_tuser),
        .value    (s_tdata[plst_pkg::DATA_W-1:0]),
        .position (s_tdata[plst_pkg::DATA_W+plst_pkg::POS_W-1:plst_pkg::DATA_W]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (m_tuser),
        .element  (element),
        .last     (m_tlast),
        .length   (length)
    );

    // Pack the result beat
    assign m_tdata = {{(plst_pkg::M_DATA_W - plst_pkg::DATA_W - plst_pkg::LEN_W){1'b0}},
                      length, element};

endmodule

// File: bench/positional_list_store_test.sv
// Self-checking bench for the positional list store: directed table, then random traffic.
`timescale 1ns / 1ps

module positional_list_store_test;

    import plst_pkg::*;

    // Operation codes that the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 300;
    localparam int QUIET_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // One result beat of the list
    typedef struct {
        status_t          status;
        logic [31:0]      element;
        logic             last;
        logic [LEN_W-1:0] length;
    } list_reply_t;

    // One row of the directed table
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [31:0]      value;
        logic [POS_W-1:0] pos;
        int               reps;
        bit               typed;
        status_t          status;
        logic [LEN_W-1:0] length;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;
    logic                m_tlast;

    logic                quiet = 1'b0;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  mismatch_count = 0;

    // Shadow of the list contents
    logic [31:0]         list_vals [CAPACITY];
    int                  list_len = 0;
    list_reply_t         awaited_replies [$];

    plan_row_t           plan [25];

    positional_list_store u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Queue one reply carrying the length after the operation
    function automatic void await_reply(status_t st, logic [31:0] elem, logic lst);
        list_reply_t r;
        r.status  = st;
        r.element = elem;
        r.last    = lst;
        r.length  = list_len[LEN_W-1:0];
        awaited_replies.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list and queue its replies
    function automatic void apply_list_op(logic [OP_W-1:0] op, logic [31:0] val,
                                          logic [POS_W-1:0] pos);
        int i;
        int p;
        p = int'(pos);
        case (op)
            OP_APPEND:
            begin
                if (list_len >= CAPACITY)
                begin
                    await_reply(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    list_vals[list_len] = val;
                    list_len++;
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            OP_INSERT:
            begin
                // Position is checked before capacity
                if (p < 1 || p > list_len + 1)
                begin
                    await_reply(ST_BADPOS, '0, 1'b1);
                end
                else if (list_len >= CAPACITY)
                begin
                    await_reply(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    for (i = list_len; i >= p; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[p-1] = val;
                    list_len++;
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            OP_REM_LAST:
            begin
                if (list_len == 0)
                begin
                    await_reply(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    list_len--;
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            OP_REM_AT:
            begin
                // Emptiness is checked before position
                if (list_len == 0)
                begin
                    await_reply(ST_EMPTY, '0, 1'b1);
                end
                else if (p < 1 || p > list_len)
                begin
                    await_reply(ST_BADPOS, '0, 1'b1);
                end
                else
                begin
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (list_len == 0)
                begin
                    await_reply(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < list_len; i++)
                        await_reply(ST_OK, list_vals[i], i + 1 == list_len);
                end
            end
            default:
            begin
                // Spare codes: no reply, list untouched
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endfunction

    // Present one beat, wait for its handshake, then predict its replies
    task automatic send_beat(logic [OP_W-1:0] op, logic [31:0] val, logic [POS_W-1:0] pos,
                             bit typed, status_t st, logic [LEN_W-1:0] len);
        list_reply_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        apply_list_op(op, val, pos);
        // Directed rows with a known answer replace the predicted one
        if (typed)
        begin
            r.status  = st;
            r.element = '0;
            r.last    = 1'b1;
            r.length  = len;
            awaited_replies[awaited_replies.size()-1] = r;
        end
    endtask

    // Downstream back-pressure in bursts, held ready during the quiet tail
    always @(posedge clk)
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1'b1;
            hold_left = $urandom_range(0, 23);
        end
    end

    // Compare each result beat with the oldest awaited reply
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                note_mismatch("unexpected result beat", '0, m_tdata[31:0]);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[31:0] !== want.element)
                    note_mismatch("element", want.element, m_tdata[31:0]);
                if (m_tlast !== want.last)
                    note_mismatch("last", 32'(want.last), 32'(m_tlast));
                if (m_tdata[36:32] !== want.length)
                    note_mismatch("length", 32'(want.length), 32'(m_tdata[36:32]));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          k;
        int          r;
        int          sent;
        bit          growing;
        logic [OP_W-1:0]  op;
        logic [31:0]      val;
        logic [POS_W-1:0] pos;

        // Directed table: empty list, extremes of value and position, full list
        plan = '{
            '{OP_DUMP,     32'h0000_0000, 8'h00, 1,  1'b1, ST_EMPTY,  5'd0},
            '{OP_REM_LAST, 32'h0000_0000, 8'hFF, 1,  1'b1, ST_EMPTY,  5'd0},
            '{OP_REM_AT,   32'h0000_0000, 8'h01, 1,  1'b1, ST_EMPTY,  5'd0},
            '{OP_INSERT,   32'h0000_1234, 8'h00, 1,  1'b1, ST_BADPOS, 5'd0},
            '{OP_INSERT,   32'h0000_1234, 8'h02, 1,  1'b1, ST_BADPOS, 5'd0},
            '{OP_APPEND,   32'h7FFF_FFFF, 8'h00, 1,  1'b1, ST_OK,     5'd1},
            '{OP_APPEND,   32'h8000_0000, 8'hFF, 1,  1'b1, ST_OK,     5'd2},
            '{OP_INSERT,   32'hFFFF_FFFF, 8'h01, 1,  1'b1, ST_OK,     5'd3},
            '{OP_INSERT,   32'h0000_0000, 8'h04, 1,  1'b1, ST_OK,     5'd4},
            '{OP_INSERT,   32'h5555_5555, 8'h03, 1,  1'b1, ST_OK,     5'd5},
            '{OP_DUMP,     32'hFFFF_FFFF, 8'hFF, 1,  1'b0, ST_OK,     5'd0},
            '{OP_REM_AT,   32'h0000_0000, 8'h00, 1,  1'b1, ST_BADPOS, 5'd5},
            '{OP_REM_AT,   32'h0000_0000, 8'h06, 1,  1'b1, ST_BADPOS, 5'd5},
            '{OP_REM_AT,   32'h0000_0000, 8'hFF, 1,  1'b1, ST_BADPOS, 5'd5},
            '{OP_REM_AT,   32'h0000_0000, 8'h03, 1,  1'b1, ST_OK,     5'd4},
            '{OP_REM_AT,   32'h0000_0000, 8'h01, 1,  1'b1, ST_OK,     5'd3},
            '{OP_REM_LAST, 32'h0000_0000, 8'h00, 1,  1'b1, ST_OK,     5'd2},
            '{OP_SPARE_HI, 32'hFFFF_FFFF, 8'hFF, 1,  1'b0, ST_OK,     5'd0},
            '{OP_DUMP,     32'h0000_0000, 8'h00, 1,  1'b0, ST_OK,     5'd0},
            '{OP_APPEND,   32'hAAAA_AAAA, 8'h00, 14, 1'b0, ST_OK,     5'd0},
            '{OP_APPEND,   32'h0000_0001, 8'h00, 1,  1'b1, ST_FULL,   5'd16},
            '{OP_INSERT,   32'h0000_0002, 8'h05, 1,  1'b1, ST_FULL,   5'd16},
            '{OP_INSERT,   32'h0000_0003, 8'h12, 1,  1'b1, ST_BADPOS, 5'd16},
            '{OP_INSERT,   32'h0000_0004, 8'h11, 1,  1'b1, ST_FULL,   5'd16},
            '{OP_DUMP,     32'h0000_0000, 8'h00, 1,  1'b0, ST_OK,     5'd0}
        };

        // Hold reset, then release at an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (n = 0; n < $size(plan); n++)
        begin
            for (k = 0; k < plan[n].reps; k++)
            begin
                send_beat(plan[n].op, plan[n].value ^ k, plan[n].pos,
                          plan[n].typed, plan[n].status, plan[n].length);
            end
        end

        // Random traffic: swing between filling and draining the list
        sent    = 0;
        growing = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            if ((growing && list_len == CAPACITY && $urandom_range(0, 2) == 0) ||
                (!growing && list_len == 0 && $urandom_range(0, 2) == 0) ||
                $urandom_range(0, 39) == 0)
                growing = !growing;

            r = $urandom_range(0, 99);
            if (r >= 95)
                op = OP_SPARE_LO + 3'($urandom_range(0, 2));
            else if (growing)
                op = (r < 40) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 80) ? OP_REM_LAST :
                     (r < 85) ? OP_REM_AT : OP_DUMP;
            else
                op = (r < 5) ? OP_APPEND : (r < 10) ? OP_INSERT : (r < 40) ? OP_REM_LAST :
                     (r < 75) ? OP_REM_AT : OP_DUMP;

            val = ($urandom_range(0, 6) == 0) ?
                  ((r[1:0] == 2'd0) ? 32'h0000_0000 : (r[1:0] == 2'd1) ? 32'hFFFF_FFFF :
                   (r[1:0] == 2'd2) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom;

            // Mostly in-range positions, sometimes anything the field allows
            if ($urandom_range(0, 4) == 0)
                pos = 8'($urandom_range(0, 255));
            else if (op == OP_INSERT)
                pos = 8'($urandom_range(1, list_len + 1));
            else if (op == OP_REM_AT && list_len > 0)
                pos = 8'($urandom_range(1, list_len));
            else
                pos = 8'($urandom_range(0, 255));

            send_beat(op, val, pos, 1'b0, ST_OK, '0);
            if (op < OP_SPARE_LO)
                sent++;
        end
        s_tvalid <= 1'b0;

        // Drain outstanding replies, then watch for stray beats
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += awaited_replies.size();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
